>>> design/kps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kps_pkg: shared types and helpers for the kinetic pan step
// Register map, sequencer states, widths and the 32-bit saturation helper.
// ----------------------------------------------------------------------------
package kps_pkg;

    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;
    localparam int VAL_W   = 32;   // Q24.8 position / velocity
    localparam int COEF_W  = 16;   // Q0.16 coefficients
    localparam int OPND_W  = 34;   // multiplier value operand
    localparam int PROD_W  = 35;   // floored product after the >> 16
    localparam int FORCE_W = 38;   // force accumulator
    localparam int SAT_W   = 40;   // saturation helper input
    localparam int QUO_W   = 24;   // divider dividend / quotient bits
    localparam int CNT_W   = 5;

    localparam logic [COEF_W-1:0] SPACING_RESET = 16'd1;

    typedef enum logic [2:0] {
        REG_RANGE_START    = 3'd0,
        REG_RANGE_END      = 3'd1,
        REG_DRAG_FRICTION  = 3'd2,
        REG_GLIDE_FRICTION = 3'd3,
        REG_EDGE_FRICTION  = 3'd4,
        REG_EDGE_SPRING    = 3'd5,
        REG_GRAB_SPRING    = 3'd6,
        REG_SNAP_SPACING   = 3'd7
    } reg_idx_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DAMP,
        ST_LO_TEST,
        ST_LO_MUL,
        ST_LO_ADD,
        ST_LO_SNAP,
        ST_HI_TEST,
        ST_HI_MUL,
        ST_HI_ADD,
        ST_HI_SNAP,
        ST_GRAB_MUL,
        ST_GRAB_ADD,
        ST_DIV_INIT,
        ST_DIV,
        ST_SNAP_TERM,
        ST_SNAP_MUL,
        ST_SNAP_ADD,
        ST_ACCEL,
        ST_VEL,
        ST_POS,
        ST_OUT
    } state_t;

    function automatic logic signed [VAL_W-1:0] sat32(input logic signed [SAT_W-1:0] x);
        logic signed [SAT_W-1:0] hi;
        logic signed [SAT_W-1:0] lo;
        hi = SAT_W'(32'sh7FFF_FFFF);
        lo = -SAT_W'(32'sh7FFF_FFFF) - SAT_W'(1);
        if (x > hi)
        begin
            return 32'sh7FFF_FFFF;
        end
        else if (x < lo)
        begin
            return 32'sh8000_0000;
        end
        else
        begin
            return x[VAL_W-1:0];
        end
    endfunction

endpackage

>>> design/kinetic_pan_snap_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kinetic_pan_snap_step: one physics tick of a kinetic pan axis
// Spring-damper with border stop and snap-to-interval pull, run on one shared
// 17x34 multiplier and a one-bit-per-cycle divider under a small sequencer.
// ----------------------------------------------------------------------------
//
//  channel   handshake                 payload
//  -------   -----------------------   ---------------------------------------
//  tick      tick_valid / tick_stall   pressed, pointer_delta
//  result    result_valid/result_stall new_position, new_velocity, accel,
//                                      snap_index, snap_changed
//  config    apb psel/penable/pwrite   paddr, pwdata, prdata (pready tied 1)
//
//  a pressed tick skips the divider; a released tick also runs the 24-step
//  restoring divider that finds the snap index, plus the multiplier passes
//  around it
//  one tick is in flight at a time: tick_stall is high from accept until the
//  result is loaded into the output register
//  a result held by result_stall holds the next tick at its final step
//  rst_n clears pan state, snap index, result_valid and config (spacing to 1)
//
module kinetic_pan_snap_step (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // tick channel
    input  logic                                  tick_valid,
    output logic                                  tick_stall,
    input  logic                                  pressed,
    input  logic signed [23:0]                    pointer_delta,
    // result channel
    output logic                                  result_valid,
    input  logic                                  result_stall,
    output logic signed [kps_pkg::VAL_W-1:0]      new_position,
    output logic signed [kps_pkg::VAL_W-1:0]      new_velocity,
    output logic signed [kps_pkg::VAL_W-1:0]      accel,
    output logic [15:0]                           snap_index,
    output logic                                  snap_changed,
    // config port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [kps_pkg::ADDR_W-1:0]            paddr,
    input  logic [kps_pkg::DATA_W-1:0]            pwdata,
    output logic [kps_pkg::DATA_W-1:0]            prdata,
    output logic                                  pready
);

    localparam int VW = kps_pkg::VAL_W;
    localparam int CW = kps_pkg::COEF_W;
    localparam int OW = kps_pkg::OPND_W;
    localparam int PW = kps_pkg::PROD_W;
    localparam int FW = kps_pkg::FORCE_W;
    localparam int SW = kps_pkg::SAT_W;
    localparam int QW = kps_pkg::QUO_W;
    localparam int NW = kps_pkg::CNT_W;

    // config registers
    logic [23:0]   range_start_reg;
    logic [23:0]   range_end_reg;
    logic [CW-1:0] drag_friction_reg;
    logic [CW-1:0] glide_friction_reg;
    logic [CW-1:0] edge_friction_reg;
    logic [CW-1:0] edge_spring_reg;
    logic [CW-1:0] grab_spring_reg;
    logic [CW-1:0] snap_spacing_reg;

    // committed pan state
    logic signed [VW-1:0] pos_reg;
    logic signed [VW-1:0] vel_reg;
    logic [15:0]          snap_reg;

    // sequencer
    kps_pkg::state_t state_reg;
    kps_pkg::state_t state_next;

    // working registers
    logic signed [VW-1:0] p_w_reg;
    logic signed [VW-1:0] v_w_reg;
    logic signed [FW-1:0] force_reg;
    logic signed [VW-1:0] accel_w_reg;
    logic                 pressed_reg;
    logic signed [23:0]   delta_reg;
    logic [CW-1:0]        coef_reg;
    logic signed [OW-1:0] opnd_reg;
    logic signed [PW-1:0] prod_reg;
    logic [15:0]          snap_new_reg;
    logic                 snap_chg_reg;

    // divider
    logic [15:0]   rem_reg;
    logic [QW-1:0] quo_reg;
    logic [7:0]    lsb_reg;
    logic          neg_reg;
    logic [NW-1:0] cnt_reg;

    // output register
    logic                 result_valid_reg;
    logic signed [VW-1:0] new_position_reg;
    logic signed [VW-1:0] new_velocity_reg;
    logic signed [VW-1:0] accel_reg;
    logic [15:0]          snap_index_reg;
    logic                 snap_changed_reg;

    // control
    logic tick_take;
    logic out_load;
    logic cfg_write;

    // datapath wires
    logic signed [VW-1:0]     rs_w;
    logic signed [VW-1:0]     re_w;
    logic [CW-1:0]            spacing_w;
    logic [CW-1:0]            damp_coef_w;
    logic signed [50:0]       mul_full_w;
    logic signed [FW-1:0]     border_sum_w;
    logic signed [23:0]       half_w;
    logic signed [32:0]       num_w;
    logic [32:0]              mag_w;
    logic [16:0]              trial_w;
    logic                     ge_w;
    logic [16:0]              diff_w;
    logic signed [25:0]       rem_s_w;
    logic [23:0]              rem_full_w;
    logic [15:0]              idx_w;
    logic                     tgt_ok_w;

    assign rs_w      = $signed({range_start_reg, 8'd0});
    assign re_w      = $signed({range_end_reg, 8'd0});
    assign spacing_w = (snap_spacing_reg == '0) ? CW'(1) : snap_spacing_reg;

    assign damp_coef_w = (pos_reg >= rs_w && pos_reg <= re_w)
                       ? (pressed ? drag_friction_reg : glide_friction_reg)
                       : edge_friction_reg;

    // shared multiplier: coefficient times value, floored back to Q.8
    assign mul_full_w = $signed({1'b0, coef_reg}) * opnd_reg;

    assign border_sum_w = FW'(p_w_reg) + FW'(v_w_reg) + force_reg;

    // snap numerator: position plus half a spacing
    assign half_w = $signed({1'b0, spacing_w, 7'd0});
    assign num_w  = 33'(p_w_reg) + 33'(half_w);
    assign mag_w  = num_w[32] ? 33'(-num_w) : 33'(num_w);

    // restoring divide step
    assign trial_w = {rem_reg, quo_reg[QW-1]};
    assign ge_w    = trial_w >= {1'b0, spacing_w};
    assign diff_w  = trial_w - {1'b0, spacing_w};

    assign rem_full_w = {rem_reg, lsb_reg};
    assign rem_s_w    = neg_reg ? -$signed({2'b00, rem_full_w})
                                : $signed({2'b00, rem_full_w});
    assign idx_w      = (quo_reg[QW-1:16] != '0) ? 16'hFFFF : quo_reg[15:0];
    assign tgt_ok_w   = !neg_reg || (quo_reg == '0);

    // ------------------------------------------------------------------
    // config port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        case (kps_pkg::reg_idx_t'(paddr[4:2]))
            kps_pkg::REG_RANGE_START:    prdata = {8'd0, range_start_reg};
            kps_pkg::REG_RANGE_END:      prdata = {8'd0, range_end_reg};
            kps_pkg::REG_DRAG_FRICTION:  prdata = {16'd0, drag_friction_reg};
            kps_pkg::REG_GLIDE_FRICTION: prdata = {16'd0, glide_friction_reg};
            kps_pkg::REG_EDGE_FRICTION:  prdata = {16'd0, edge_friction_reg};
            kps_pkg::REG_EDGE_SPRING:    prdata = {16'd0, edge_spring_reg};
            kps_pkg::REG_GRAB_SPRING:    prdata = {16'd0, grab_spring_reg};
            kps_pkg::REG_SNAP_SPACING:   prdata = {16'd0, snap_spacing_reg};
            default:                     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_start_reg    <= '0;
            range_end_reg      <= '0;
            drag_friction_reg  <= '0;
            glide_friction_reg <= '0;
            edge_friction_reg  <= '0;
            edge_spring_reg    <= '0;
            grab_spring_reg    <= '0;
            snap_spacing_reg   <= kps_pkg::SPACING_RESET;
        end
        else if (cfg_write)
        begin
            case (kps_pkg::reg_idx_t'(paddr[4:2]))
                kps_pkg::REG_RANGE_START:    range_start_reg    <= pwdata[23:0];
                kps_pkg::REG_RANGE_END:      range_end_reg      <= pwdata[23:0];
                kps_pkg::REG_DRAG_FRICTION:  drag_friction_reg  <= pwdata[CW-1:0];
                kps_pkg::REG_GLIDE_FRICTION: glide_friction_reg <= pwdata[CW-1:0];
                kps_pkg::REG_EDGE_FRICTION:  edge_friction_reg  <= pwdata[CW-1:0];
                kps_pkg::REG_EDGE_SPRING:    edge_spring_reg    <= pwdata[CW-1:0];
                kps_pkg::REG_GRAB_SPRING:    grab_spring_reg    <= pwdata[CW-1:0];
                kps_pkg::REG_SNAP_SPACING:   snap_spacing_reg   <= pwdata[CW-1:0];
                default:                     snap_spacing_reg   <= snap_spacing_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            kps_pkg::ST_IDLE:
            begin
                if (tick_valid)
                begin
                    state_next = kps_pkg::ST_DAMP;
                end
            end
            kps_pkg::ST_DAMP:     state_next = kps_pkg::ST_LO_TEST;
            kps_pkg::ST_LO_TEST:
            begin
                state_next = (p_w_reg < rs_w) ? kps_pkg::ST_LO_MUL : kps_pkg::ST_HI_TEST;
            end
            kps_pkg::ST_LO_MUL:   state_next = kps_pkg::ST_LO_ADD;
            kps_pkg::ST_LO_ADD:   state_next = kps_pkg::ST_LO_SNAP;
            kps_pkg::ST_LO_SNAP:  state_next = kps_pkg::ST_HI_TEST;
            kps_pkg::ST_HI_TEST:
            begin
                if (p_w_reg > re_w)
                begin
                    state_next = kps_pkg::ST_HI_MUL;
                end
                else
                begin
                    state_next = pressed_reg ? kps_pkg::ST_GRAB_MUL : kps_pkg::ST_DIV_INIT;
                end
            end
            kps_pkg::ST_HI_MUL:   state_next = kps_pkg::ST_HI_ADD;
            kps_pkg::ST_HI_ADD:   state_next = kps_pkg::ST_HI_SNAP;
            kps_pkg::ST_HI_SNAP:
            begin
                state_next = pressed_reg ? kps_pkg::ST_GRAB_MUL : kps_pkg::ST_DIV_INIT;
            end
            kps_pkg::ST_GRAB_MUL: state_next = kps_pkg::ST_GRAB_ADD;
            kps_pkg::ST_GRAB_ADD: state_next = kps_pkg::ST_ACCEL;
            kps_pkg::ST_DIV_INIT: state_next = kps_pkg::ST_DIV;
            kps_pkg::ST_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = kps_pkg::ST_SNAP_TERM;
                end
            end
            kps_pkg::ST_SNAP_TERM: state_next = kps_pkg::ST_SNAP_MUL;
            kps_pkg::ST_SNAP_MUL:  state_next = kps_pkg::ST_SNAP_ADD;
            kps_pkg::ST_SNAP_ADD:  state_next = kps_pkg::ST_ACCEL;
            kps_pkg::ST_ACCEL:     state_next = kps_pkg::ST_VEL;
            kps_pkg::ST_VEL:       state_next = kps_pkg::ST_POS;
            kps_pkg::ST_POS:       state_next = kps_pkg::ST_OUT;
            kps_pkg::ST_OUT:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    state_next = kps_pkg::ST_IDLE;
                end
            end
            default:               state_next = kps_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        tick_stall = 1'b1;
        tick_take  = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            kps_pkg::ST_IDLE:
            begin
                tick_stall = 1'b0;
                tick_take  = tick_valid;
            end
            kps_pkg::ST_OUT:
            begin
                out_load = !result_valid_reg || !result_stall;
            end
            default:
            begin
                tick_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= kps_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // datapath
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        case (state_reg)
            kps_pkg::ST_IDLE:
            begin
                if (tick_take)
                begin
                    p_w_reg      <= pos_reg;
                    v_w_reg      <= vel_reg;
                    pressed_reg  <= pressed;
                    delta_reg    <= pointer_delta;
                    coef_reg     <= damp_coef_w;
                    opnd_reg     <= OW'(vel_reg);
                    snap_new_reg <= snap_reg;
                    snap_chg_reg <= 1'b0;
                end
            end
            kps_pkg::ST_DAMP, kps_pkg::ST_LO_MUL, kps_pkg::ST_HI_MUL,
            kps_pkg::ST_GRAB_MUL, kps_pkg::ST_SNAP_MUL:
            begin
                prod_reg <= mul_full_w[50:16];
            end
            kps_pkg::ST_LO_TEST:
            begin
                force_reg <= -FW'(prod_reg);
                coef_reg  <= edge_spring_reg;
                opnd_reg  <= OW'(rs_w) - OW'(p_w_reg);
            end
            kps_pkg::ST_LO_ADD, kps_pkg::ST_GRAB_ADD, kps_pkg::ST_SNAP_ADD:
            begin
                force_reg <= force_reg + FW'(prod_reg);
            end
            kps_pkg::ST_LO_SNAP:
            begin
                // released axis stops on the lower border
                if (!pressed_reg && border_sum_w >= FW'(rs_w))
                begin
                    v_w_reg   <= '0;
                    force_reg <= '0;
                    p_w_reg   <= rs_w;
                end
            end
            kps_pkg::ST_HI_TEST:
            begin
                if (p_w_reg > re_w)
                begin
                    coef_reg <= edge_spring_reg;
                    opnd_reg <= OW'(p_w_reg) - OW'(re_w);
                end
                else
                begin
                    coef_reg <= grab_spring_reg;
                    opnd_reg <= OW'(delta_reg);
                end
            end
            kps_pkg::ST_HI_ADD:
            begin
                force_reg <= force_reg - FW'(prod_reg);
            end
            kps_pkg::ST_HI_SNAP:
            begin
                if (!pressed_reg && border_sum_w <= FW'(re_w))
                begin
                    v_w_reg   <= '0;
                    force_reg <= '0;
                    p_w_reg   <= re_w;
                end
                coef_reg <= grab_spring_reg;
                opnd_reg <= OW'(delta_reg);
            end
            kps_pkg::ST_DIV_INIT:
            begin
                // divide magnitude by 256*spacing: low 8 bits pass to the remainder
                neg_reg <= num_w[32];
                quo_reg <= mag_w[31:8];
                lsb_reg <= mag_w[7:0];
                rem_reg <= '0;
                cnt_reg <= NW'(QW - 1);
            end
            kps_pkg::ST_DIV:
            begin
                rem_reg <= ge_w ? diff_w[15:0] : trial_w[15:0];
                quo_reg <= {quo_reg[QW-2:0], ge_w};
                cnt_reg <= cnt_reg - NW'(1);
            end
            kps_pkg::ST_SNAP_TERM:
            begin
                // target*d - pos equals half spacing minus the signed remainder
                coef_reg <= edge_spring_reg;
                opnd_reg <= OW'(half_w) - OW'(rem_s_w);
                if (tgt_ok_w && idx_w != snap_reg)
                begin
                    snap_new_reg <= idx_w;
                    snap_chg_reg <= 1'b1;
                end
            end
            kps_pkg::ST_ACCEL:
            begin
                accel_w_reg <= kps_pkg::sat32(SW'(force_reg - FW'(delta_reg)));
            end
            kps_pkg::ST_VEL:
            begin
                v_w_reg <= kps_pkg::sat32(SW'(v_w_reg) + SW'(accel_w_reg));
            end
            kps_pkg::ST_POS:
            begin
                if (pressed_reg)
                begin
                    p_w_reg <= kps_pkg::sat32(SW'(p_w_reg) - SW'(delta_reg));
                end
                else
                begin
                    p_w_reg <= kps_pkg::sat32(SW'(p_w_reg) + SW'(v_w_reg));
                end
            end
            default:
            begin
                prod_reg <= prod_reg;
            end
        endcase
    end

    // committed state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg          <= '0;
            vel_reg          <= '0;
            snap_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            pos_reg          <= p_w_reg;
            vel_reg          <= v_w_reg;
            snap_reg         <= snap_new_reg;
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            new_position_reg <= p_w_reg;
            new_velocity_reg <= v_w_reg;
            accel_reg        <= accel_w_reg;
            snap_index_reg   <= snap_new_reg;
            snap_changed_reg <= snap_chg_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign new_position = new_position_reg;
    assign new_velocity = new_velocity_reg;
    assign accel        = accel_reg;
    assign snap_index   = snap_index_reg;
    assign snap_changed = snap_changed_reg;

`ifndef SYNTHESIS
    // an accepted transaction always starts at the damping pass
    assert property (@(posedge clk) disable iff (!rst_n)
        tick_valid && !tick_stall |=> state_reg == kps_pkg::ST_DAMP)
        else $error("accepted transaction did not start the sequencer");

    // divider remainder stays below the spacing
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == kps_pkg::ST_DIV |-> rem_reg < spacing_w)
        else $error("divider remainder out of range");

    // a pressed tick never reports a snap change
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == kps_pkg::ST_OUT && pressed_reg |-> !snap_chg_reg)
        else $error("snap change flagged on pressed tick");

    // a flagged snap change really moves the committed index
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load && snap_chg_reg |=> snap_reg != $past(snap_reg))
        else $error("snap change flagged without new index");

    // a new result only appears from the final step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(state_reg == kps_pkg::ST_OUT))
        else $error("result raised outside the final step");
`endif

endmodule

>>> tb/tb_kinetic_pan_snap_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_kinetic_pan_snap_step: self-checking bench for the kinetic pan step
// Drives physics ticks through the valid/stall channel and programs the axis
// over apb. A bit-true predictor of position, velocity, damping, border springs
// and snap index runs beside the block; every result transaction is compared
// field by field. Directed ticks first, then press/release gestures with random
// content under random settings, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_kinetic_pan_snap_step;

    localparam int     QUIET_LIMIT = 4000;
    localparam longint S32_HI      = 64'sd2147483647;
    localparam longint S32_LO      = -64'sd2147483648;

    typedef struct {
        logic signed [31:0] position;
        logic signed [31:0] velocity;
        logic signed [31:0] push;
        logic [15:0]        index;
        logic               moved;
    } pan_result_t;

    logic                             clk           = 1'b0;
    logic                             rst_n         = 1'b0;
    logic                             tick_valid    = 1'b0;
    logic                             tick_stall;
    logic                             pressed       = 1'b0;
    logic signed [23:0]               pointer_delta = '0;
    logic                             result_valid;
    logic                             result_stall  = 1'b0;
    logic signed [kps_pkg::VAL_W-1:0] new_position;
    logic signed [kps_pkg::VAL_W-1:0] new_velocity;
    logic signed [kps_pkg::VAL_W-1:0] accel;
    logic [15:0]                      snap_index;
    logic                             snap_changed;
    logic                             psel          = 1'b0;
    logic                             penable       = 1'b0;
    logic                             pwrite        = 1'b0;
    logic [kps_pkg::ADDR_W-1:0]       paddr         = '0;
    logic [kps_pkg::DATA_W-1:0]       pwdata        = '0;
    logic [kps_pkg::DATA_W-1:0]       prdata;
    logic                             pready;

    // predictor copy of the axis settings and pan state
    logic signed [23:0] cfg_range_start    = '0;
    logic signed [23:0] cfg_range_end      = '0;
    logic [15:0]        cfg_drag_friction  = '0;
    logic [15:0]        cfg_glide_friction = '0;
    logic [15:0]        cfg_edge_friction  = '0;
    logic [15:0]        cfg_edge_spring    = '0;
    logic [15:0]        cfg_grab_spring    = '0;
    logic [15:0]        cfg_snap_spacing   = kps_pkg::SPACING_RESET;
    longint             pan_pos            = 0;
    longint             pan_vel            = 0;
    logic [15:0]        snap_cur           = '0;

    pan_result_t pending_ticks[$];
    int          errors          = 0;
    int          results_checked = 0;
    int          ticks_pressed   = 0;
    int          ticks_released  = 0;
    int          border_stops    = 0;
    int          snap_moves      = 0;
    int          settings_loaded = 0;
    int          quiet_cycles    = 0;
    bit          steady_flow     = 1'b0;

    kinetic_pan_snap_step dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .tick_valid    (tick_valid),
        .tick_stall    (tick_stall),
        .pressed       (pressed),
        .pointer_delta (pointer_delta),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .new_position  (new_position),
        .new_velocity  (new_velocity),
        .accel         (accel),
        .snap_index    (snap_index),
        .snap_changed  (snap_changed),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 clk = ~clk;

    // coefficient times a q.8 value, floored back to q.8
    function automatic longint damp_mul(input logic [15:0] coef, input longint v);
        return (longint'(coef) * v) >>> 16;
    endfunction

    function automatic longint clamp32(input longint x);
        if (x > S32_HI)
        begin
            return S32_HI;
        end
        if (x < S32_LO)
        begin
            return S32_LO;
        end
        return x;
    endfunction

    function automatic void predict_tick(input logic down, input logic signed [23:0] move);
        longint      delta;
        longint      lo_edge;
        longint      hi_edge;
        longint      ps;
        longint      vl;
        longint      pull;
        longint      acc;
        longint      spc;
        longint      unit;
        longint      target;
        logic [15:0] idx;
        pan_result_t r;
        delta   = longint'(move);
        lo_edge = longint'(cfg_range_start) * 256;
        hi_edge = longint'(cfg_range_end) * 256;
        spc     = (cfg_snap_spacing == 16'd0) ? 64'sd1 : longint'(cfg_snap_spacing);
        ps      = pan_pos;
        vl      = pan_vel;
        r.moved = 1'b0;
        if (ps >= lo_edge && ps <= hi_edge)
        begin
            pull = -damp_mul(down ? cfg_drag_friction : cfg_glide_friction, vl);
        end
        else
        begin
            pull = -damp_mul(cfg_edge_friction, vl);
        end
        if (ps < lo_edge)
        begin
            pull += damp_mul(cfg_edge_spring, lo_edge - ps);
            if (!down && ps + vl + pull >= lo_edge)
            begin
                vl = 0;
                pull = 0;
                ps = lo_edge;
                border_stops++;
            end
        end
        // upper test sees the position after a lower stop
        if (ps > hi_edge)
        begin
            pull -= damp_mul(cfg_edge_spring, ps - hi_edge);
            if (!down && ps + vl + pull <= hi_edge)
            begin
                vl = 0;
                pull = 0;
                ps = hi_edge;
                border_stops++;
            end
        end
        if (down)
        begin
            pull += damp_mul(cfg_grab_spring, delta);
            acc = clamp32(pull - delta);
            vl  = clamp32(vl + acc);
            ps  = clamp32(ps - delta);
        end
        else
        begin
            unit   = spc * 256;
            target = (ps + spc * 128) / unit;
            pull  += damp_mul(cfg_edge_spring, target * unit - ps);
            if (target >= 0)
            begin
                idx = (target > 65535) ? 16'hFFFF : target[15:0];
                if (idx != snap_cur)
                begin
                    snap_cur = idx;
                    r.moved  = 1'b1;
                    snap_moves++;
                end
            end
            acc = clamp32(pull - delta);
            vl  = clamp32(vl + acc);
            ps  = clamp32(ps + vl);
        end
        pan_pos    = ps;
        pan_vel    = vl;
        r.position = ps[31:0];
        r.velocity = vl[31:0];
        r.push     = acc[31:0];
        r.index    = snap_cur;
        pending_ticks.push_back(r);
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // result side: random stall and comparison against the oldest prediction
    always @(posedge clk)
    begin
        pan_result_t want;
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (pending_ticks.size() == 0)
                begin
                    $display("%0t ns: result transaction with no tick pending, position %0d",
                             $time, new_position);
                    errors++;
                end
                else
                begin
                    want = pending_ticks.pop_front();
                    results_checked++;
                    check_field("new_position", want.position, new_position);
                    check_field("new_velocity", want.velocity, new_velocity);
                    check_field("accel", want.push, accel);
                    check_field("snap_index", want.index, snap_index);
                    check_field("snap_changed", want.moved, snap_changed);
                end
            end
            result_stall <= !steady_flow && ($urandom_range(0, 99) < 13);
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (!rst_n || (tick_valid && !tick_stall) || (result_valid && !result_stall))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t ns: no transaction for %0d cycles", $time, QUIET_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic send_tick(input logic down, input logic signed [23:0] move);
        while (!steady_flow && $urandom_range(0, 99) < 13)
        begin
            tick_valid <= 1'b0;
            @(posedge clk);
        end
        tick_valid    <= 1'b1;
        pressed       <= down;
        pointer_delta <= move;
        @(posedge clk);
        while (tick_stall)
        begin
            @(posedge clk);
        end
        if (down)
        begin
            ticks_pressed++;
        end
        else
        begin
            ticks_released++;
        end
        predict_tick(down, move);
    endtask

    task automatic wait_drained();
        tick_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending_ticks.size() != 0);
    endtask

    task automatic write_reg(input kps_pkg::reg_idx_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            kps_pkg::REG_RANGE_START:    cfg_range_start    = value[23:0];
            kps_pkg::REG_RANGE_END:      cfg_range_end      = value[23:0];
            kps_pkg::REG_DRAG_FRICTION:  cfg_drag_friction  = value[15:0];
            kps_pkg::REG_GLIDE_FRICTION: cfg_glide_friction = value[15:0];
            kps_pkg::REG_EDGE_FRICTION:  cfg_edge_friction  = value[15:0];
            kps_pkg::REG_EDGE_SPRING:    cfg_edge_spring    = value[15:0];
            kps_pkg::REG_GRAB_SPRING:    cfg_grab_spring    = value[15:0];
            kps_pkg::REG_SNAP_SPACING:   cfg_snap_spacing   = value[15:0];
            default:                     ;
        endcase
        @(posedge clk);
    endtask

    // block must be idle: call only after wait_drained
    task automatic load_settings(
        input logic signed [23:0] lo,
        input logic signed [23:0] hi,
        input logic [15:0]        drag,
        input logic [15:0]        glide,
        input logic [15:0]        efric,
        input logic [15:0]        espring,
        input logic [15:0]        grab,
        input logic [15:0]        spacing
    );
        write_reg(kps_pkg::REG_RANGE_START, 32'(lo));
        write_reg(kps_pkg::REG_RANGE_END, 32'(hi));
        write_reg(kps_pkg::REG_DRAG_FRICTION, 32'(drag));
        write_reg(kps_pkg::REG_GLIDE_FRICTION, 32'(glide));
        write_reg(kps_pkg::REG_EDGE_FRICTION, 32'(efric));
        write_reg(kps_pkg::REG_EDGE_SPRING, 32'(espring));
        write_reg(kps_pkg::REG_GRAB_SPRING, 32'(grab));
        write_reg(kps_pkg::REG_SNAP_SPACING, 32'(spacing));
        settings_loaded++;
    endtask

    function automatic logic signed [23:0] pick_edge();
        case ($urandom_range(0, 5))
            0:       return 24'sh800000;
            1:       return 24'sh7FFFFF;
            default: return 24'(int'($urandom_range(0, 8000)) - 4000);
        endcase
    endfunction

    function automatic logic [15:0] pick_coef();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic signed [23:0] pick_delta(input int spread);
        case ($urandom_range(0, 19))
            0:       return 24'($urandom);
            1:       return 24'sh800000;
            2:       return 24'sh7FFFFF;
            default: return 24'(int'($urandom_range(0, 2 * spread)) - spread);
        endcase
    endfunction

    function automatic logic signed [23:0] release_delta();
        if ($urandom_range(0, 3) == 0)
        begin
            return pick_delta(64);
        end
        return 24'sd0;
    endfunction

    task automatic test_reset_defaults();
        send_tick(1'b0, 24'sd0);
        send_tick(1'b1, 24'sd256);
        send_tick(1'b0, 24'sd0);
        send_tick(1'b0, 24'sd0);
    endtask

    // pointer extremes, then glides back against both borders
    task automatic test_border_and_pointer();
        wait_drained();
        load_settings(24'sd0, 24'sd1000, 16'h2000, 16'h1000, 16'h8000, 16'h4000,
                      16'h8000, 16'd10);
        send_tick(1'b1, 24'sh7FFFFF);
        send_tick(1'b1, 24'sd0);
        repeat (3) send_tick(1'b0, 24'sd0);
        send_tick(1'b1, 24'sh800000);
        send_tick(1'b1, -24'sd1);
        repeat (3) send_tick(1'b0, 24'sd0);
        send_tick(1'b1, 24'sd1);
    endtask

    // full range, zero spacing, huge and negative snap targets
    task automatic test_extreme_settings();
        wait_drained();
        load_settings(24'sh800000, 24'sh7FFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000,
                      16'hFFFF, 16'd0);
        repeat (3) send_tick(1'b1, 24'sh800000);
        repeat (2) send_tick(1'b0, 24'sd0);
        repeat (4) send_tick(1'b1, 24'sh7FFFFF);
        send_tick(1'b0, 24'sd0);
        send_tick(1'b0, 24'sh7FFFFF);
    endtask

    // drag-and-fling gestures with random content, some noise, new settings per phase
    task automatic test_random_gestures(input int phases, input int per_phase);
        logic signed [23:0] lo;
        logic signed [23:0] hi;
        logic signed [23:0] swap;
        logic [15:0]        spacing;
        int                 sent;
        int                 hold;
        for (int ph = 0; ph < phases; ph++)
        begin
            wait_drained();
            steady_flow = (ph == 1);
            lo = pick_edge();
            hi = pick_edge();
            if (lo > hi && $urandom_range(0, 5) != 0)
            begin
                swap = lo;
                lo   = hi;
                hi   = swap;
            end
            case ($urandom_range(0, 7))
                0:       spacing = 16'd0;
                1:       spacing = 16'hFFFF;
                2:       spacing = 16'($urandom_range(0, 65535));
                default: spacing = 16'($urandom_range(1, 256));
            endcase
            load_settings(lo, hi, pick_coef(), pick_coef(), pick_coef(), pick_coef(),
                          pick_coef(), spacing);
            sent = 0;
            while (sent < per_phase)
            begin
                if ($urandom_range(0, 9) < 8)
                begin
                    hold = $urandom_range(1, 12);
                    repeat (hold) send_tick(1'b1, pick_delta(3000));
                    sent += hold;
                    hold = $urandom_range(5, 40);
                    repeat (hold) send_tick(1'b0, release_delta());
                    sent += hold;
                end
                else
                begin
                    hold = $urandom_range(1, 10);
                    repeat (hold) send_tick(1'($urandom_range(0, 1)), pick_delta(50000));
                    sent += hold;
                end
            end
        end
        steady_flow = 1'b0;
    endtask

    // short bursts, each followed by a full drain of the result side
    task automatic test_drained_bursts(input int bursts);
        int hold;
        for (int b = 0; b < bursts; b++)
        begin
            hold = $urandom_range(1, 8);
            repeat (hold) send_tick(1'($urandom_range(0, 1)), pick_delta(3000));
            wait_drained();
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_border_and_pointer();
        test_extreme_settings();
        test_random_gestures(8, 200);
        test_drained_bursts(25);

        wait_drained();
        repeat (60) @(posedge clk);
        errors += pending_ticks.size();

        $display("run covered %0d pressed and %0d released ticks over %0d axis settings,",
                 ticks_pressed, ticks_released, settings_loaded + 1);
        $display("%0d border stops, %0d snap index changes, %0d results compared",
                 border_stops, snap_moves, results_checked);
        if (errors == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
